// ----- src/hsvrgb_pkg.sv -----
// HSV to RGB converter: shared types and constants.
// Item structs, hue sector codes, pipeline enable bundle and divider constants.
// No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  // Field widths of the item structs
  localparam int HUE_W  = 15;
  localparam int SV_W   = 13;
  localparam int CHAN_W = 8;

  // Final divide by 600000 as multiply by rounded-up reciprocal, exact for N_W-bit numerators
  localparam int          N_W         = 28;
  localparam int          RECIP_SHIFT = 48;
  localparam int          RECIP_W     = 29;
  localparam logic [63:0] DIV_DEN     = 64'd600000;
  localparam logic [63:0] RECIP64     =
    ((64'd1 << RECIP_SHIFT) + DIV_DEN - 64'd1) / DIV_DEN;
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SV_W-1:0]  saturation;
    logic [SV_W-1:0]  brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              out_of_range;
  } rgb_t;

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  // Stage 1 result shared with the top level
  typedef struct packed {
    logic [SV_W-1:0] sat;
    logic [SV_W-1:0] bri;
    sector_t         sector;
    logic            oor;
  } hsvrgb_s1_t;

  // Load enables of the channel lane stages
  typedef struct packed {
    logic st2;
    logic st3;
    logic st4;
    logic st5;
  } hsvrgb_lane_en_t;

endpackage

// ----- src/hsvrgb_sector.sv -----
// HSV to RGB converter: stage 1, range check and hue sector decode.
// Registers sector, distance from sector pair centre and the S/V operands.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_sector
  import hsvrgb_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  hsv_t                                         hsv,
  output hsvrgb_s1_t                                   s1,
  output logic [$clog2((60 << FRAC_BITS) + 1)-1:0]     sec_dist
);

  localparam int HX_MIN = $clog2((360 << FRAC_BITS) + 1);
  localparam int HX_W   = (HX_MIN > HUE_W) ? HX_MIN : HUE_W;
  localparam int SX_MIN = $clog2((100 << FRAC_BITS) + 1);
  localparam int SX_W   = (SX_MIN > SV_W) ? SX_MIN : SV_W;
  localparam int D_W    = $clog2((60 << FRAC_BITS) + 1);

  localparam logic [HX_W-1:0] H60  = HX_W'(60 << FRAC_BITS);
  localparam logic [HX_W-1:0] H120 = HX_W'(120 << FRAC_BITS);
  localparam logic [HX_W-1:0] H180 = HX_W'(180 << FRAC_BITS);
  localparam logic [HX_W-1:0] H240 = HX_W'(240 << FRAC_BITS);
  localparam logic [HX_W-1:0] H300 = HX_W'(300 << FRAC_BITS);
  localparam logic [HX_W-1:0] H360 = HX_W'(360 << FRAC_BITS);
  localparam logic [SX_W-1:0] P100 = SX_W'(100 << FRAC_BITS);

  logic [HX_W-1:0] hue_x;
  logic [SX_W-1:0] sat_x;
  logic [SX_W-1:0] bri_x;
  logic [HX_W-1:0] base;
  logic [HX_W-1:0] u;
  logic [HX_W-1:0] dist_x;
  hsvrgb_s1_t      s1_next;

  always_comb begin
    hue_x = HX_W'(hsv.hue);
    sat_x = SX_W'(hsv.saturation);
    bri_x = SX_W'(hsv.brightness);

    s1_next.sat = hsv.saturation;
    s1_next.bri = hsv.brightness;
    s1_next.oor = (hue_x > H360) || (sat_x > P100) || (bri_x > P100);

    // hue of exactly 360 lands in the last sector
    if (hue_x >= H300) begin
      s1_next.sector = SEC_M_TO_R;
    end else if (hue_x >= H240) begin
      s1_next.sector = SEC_B_TO_M;
    end else if (hue_x >= H180) begin
      s1_next.sector = SEC_C_TO_B;
    end else if (hue_x >= H120) begin
      s1_next.sector = SEC_G_TO_C;
    end else if (hue_x >= H60) begin
      s1_next.sector = SEC_Y_TO_G;
    end else begin
      s1_next.sector = SEC_R_TO_Y;
    end

    // start of the 120-degree sector pair
    case (s1_next.sector)
      SEC_R_TO_Y, SEC_Y_TO_G: base = '0;
      SEC_G_TO_C, SEC_C_TO_B: base = H120;
      SEC_B_TO_M, SEC_M_TO_R: base = H240;
      default:                base = '0;
    endcase

    // |u - 60| is 60 minus the secondary weight w
    u      = hue_x - base;
    dist_x = (u >= H60) ? (u - H60) : (H60 - u);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= s1_next;
      sec_dist <= dist_x[D_W-1:0];
    end
  end

endmodule

// ----- src/hsvrgb_lane.sv -----
// HSV to RGB converter: one channel lane, stages 2 to 5.
// Computes floor(255 * v * (6000f^2 - s*d) / (600000 f^3)) for a distance d.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_lane
  import hsvrgb_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic                                         clk,
  input  hsvrgb_lane_en_t                              en,
  input  logic [SV_W-1:0]                              sat,
  input  logic [SV_W-1:0]                              bri,
  input  logic [$clog2((60 << FRAC_BITS) + 1)-1:0]     sec_dist,
  output logic [CHAN_W-1:0]                            chan
);

  localparam int          D_W      = $clog2((60 << FRAC_BITS) + 1);
  localparam logic [63:0] P_FULL64 = 64'd6000 << (2 * FRAC_BITS);
  localparam int          P_W      = $clog2(P_FULL64 + 64'd1);
  localparam logic [P_W-1:0] P_FULL = P_FULL64[P_W-1:0];
  localparam int          SD_W     = SV_W + D_W;
  localparam int          PX_W     = (SD_W > P_W) ? SD_W : P_W;
  localparam int          M_W      = SV_W + P_W;
  localparam int          Y_W      = M_W + 8;
  localparam int          SHIFT    = 3 * FRAC_BITS;

  logic [SD_W-1:0]            sd;
  logic [PX_W-1:0]            sd_x;
  logic [P_W-1:0]             p_next;
  logic [P_W-1:0]             p;
  logic [SV_W-1:0]            bri2;
  logic [M_W-1:0]             prod_next;
  logic [M_W-1:0]             prod;
  logic [Y_W-1:0]             y;
  logic [Y_W-1:0]             y_sh;
  logic [N_W-1:0]             n;
  logic [N_W+RECIP_W-1:0]     qp;

  // Stage 2: weight p = 6000f^2 - s*d
  always_comb begin
    sd     = SD_W'(sat) * SD_W'(sec_dist);
    sd_x   = PX_W'(sd);
    p_next = P_FULL - sd_x[P_W-1:0];
  end

  // Stage 3: v * p
  always_comb begin
    prod_next = M_W'(bri2) * M_W'(p);
  end

  // Stage 4: times 255, drop the f^3 part of the divisor
  always_comb begin
    y    = {prod, 8'b0} - Y_W'(prod);
    y_sh = y >> SHIFT;
  end

  // Stage 5: divide by 600000 by reciprocal
  always_comb begin
    qp = (N_W + RECIP_W)'(n) * (N_W + RECIP_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en.st2) begin
      p    <= p_next;
      bri2 <= bri;
    end
    if (en.st3) begin
      prod <= prod_next;
    end
    if (en.st4) begin
      n <= y_sh[N_W-1:0];
    end
    if (en.st5) begin
      chan <= qp[RECIP_SHIFT +: CHAN_W];
    end
  end

endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// HSV to RGB converter: top level, pipeline control and output stage.
// Instantiates hsvrgb_sector and three hsvrgb_lane; depends on hsvrgb_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel hsv / hsv_valid / hsv_stall carries one colour per item:
//   hue in degrees, saturation and value in percent, FRAC_BITS fraction bits.
//   Output channel rgb / rgb_valid / rgb_stall returns one item per input
//   item, in order: 8-bit red, green, blue and an out-of-range flag. Hue
//   above 360 or saturation or value above 100 gives black with the flag set.
//   Six register stages: sector decode, s*d weight, v*p product, scale by
//   255, reciprocal divide, channel select. Throughput is one item per
//   clock while rgb_stall is low; the stages have their own valid bits,
//   so empty stages are filled even while a finished item waits.
//   When rgb_stall is held, the output holds and the stages behind it fill
//   up; hsv_stall rises only once all six stages hold an item.
//   Reset (rst, synchronous) empties the pipeline; no item is in flight after.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  output logic hsv_stall,
  input  hsv_t hsv,
  output logic rgb_valid,
  input  logic rgb_stall,
  output rgb_t rgb
);

  localparam int D_W = $clog2((60 << FRAC_BITS) + 1);

  localparam logic [D_W-1:0] DIST_ZERO  = '0;
  localparam logic [D_W-1:0] DIST_SIXTY = D_W'(60 << FRAC_BITS);

  logic [6:1]        vld;
  logic [6:1]        en;
  hsvrgb_lane_en_t   lane_en;
  hsvrgb_s1_t        s1;
  logic [D_W-1:0]    dist_mid;
  sector_t           sector_d [2:5];
  logic              oor_d    [2:5];
  logic [CHAN_W-1:0] c_max;
  logic [CHAN_W-1:0] c_mid;
  logic [CHAN_W-1:0] c_min;
  rgb_t              rgb_next;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    en[6] = !vld[6] || !rgb_stall;
    en[5] = !vld[5] || en[6];
    en[4] = !vld[4] || en[5];
    en[3] = !vld[3] || en[4];
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
    hsv_stall   = !en[1];
    lane_en.st2 = en[2];
    lane_en.st3 = en[3];
    lane_en.st4 = en[4];
    lane_en.st5 = en[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= hsv_valid;
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
      if (en[6]) vld[6] <= vld[5];
    end
  end

  hsvrgb_sector #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sector (
    .clk      (clk),
    .en       (en[1]),
    .hsv      (hsv),
    .s1       (s1),
    .sec_dist (dist_mid)
  );

  // Brightest channel: d = 0
  hsvrgb_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_max (
    .clk      (clk),
    .en       (lane_en),
    .sat      (s1.sat),
    .bri      (s1.bri),
    .sec_dist (DIST_ZERO),
    .chan     (c_max)
  );

  // Secondary channel: d = |u - 60|
  hsvrgb_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_mid (
    .clk      (clk),
    .en       (lane_en),
    .sat      (s1.sat),
    .bri      (s1.bri),
    .sec_dist (dist_mid),
    .chan     (c_mid)
  );

  // Darkest channel: d = 60
  hsvrgb_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_min (
    .clk      (clk),
    .en       (lane_en),
    .sat      (s1.sat),
    .bri      (s1.bri),
    .sec_dist (DIST_SIXTY),
    .chan     (c_min)
  );

  // Sector and range flag ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sector_d[2] <= s1.sector;
      oor_d[2]    <= s1.oor;
    end
    if (en[3]) begin
      sector_d[3] <= sector_d[2];
      oor_d[3]    <= oor_d[2];
    end
    if (en[4]) begin
      sector_d[4] <= sector_d[3];
      oor_d[4]    <= oor_d[3];
    end
    if (en[5]) begin
      sector_d[5] <= sector_d[4];
      oor_d[5]    <= oor_d[4];
    end
  end

  // Stage 6: place the three levels by sector, black when out of range
  always_comb begin
    case (sector_d[5])
      SEC_R_TO_Y: begin
        rgb_next.red = c_max; rgb_next.green = c_mid; rgb_next.blue = c_min;
      end
      SEC_Y_TO_G: begin
        rgb_next.red = c_mid; rgb_next.green = c_max; rgb_next.blue = c_min;
      end
      SEC_G_TO_C: begin
        rgb_next.red = c_min; rgb_next.green = c_max; rgb_next.blue = c_mid;
      end
      SEC_C_TO_B: begin
        rgb_next.red = c_min; rgb_next.green = c_mid; rgb_next.blue = c_max;
      end
      SEC_B_TO_M: begin
        rgb_next.red = c_mid; rgb_next.green = c_min; rgb_next.blue = c_max;
      end
      default: begin
        rgb_next.red = c_max; rgb_next.green = c_min; rgb_next.blue = c_mid;
      end
    endcase
    rgb_next.out_of_range = oor_d[5];
    if (oor_d[5]) begin
      rgb_next.red   = '0;
      rgb_next.green = '0;
      rgb_next.blue  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rgb <= rgb_next;
    end
  end

  assign rgb_valid = vld[6];

  // Input stalls only with a full pipeline held by the receiver
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (&vld && rgb_stall))
    else $error("input stalled with an empty stage");

  // A taken item with nothing behind it leaves the output empty
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_stall && !vld[5]) |=> !rgb_valid)
    else $error("output item appeared without a source");

  // Out-of-range items leave as black
  a_oor_black: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && rgb.out_of_range) |->
      (rgb.red == '0 && rgb.green == '0 && rgb.blue == '0))
    else $error("out-of-range item not black");

  // Lane levels are ordered for in-range items
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !oor_d[5]) |-> (c_min <= c_mid && c_mid <= c_max))
    else $error("channel levels out of order");

  // A held output keeps its item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(rgb)))
    else $error("stalled output item changed");

endmodule

// ----- verif/hsvrgb_colour_checker.sv -----
// HSV to RGB converter: checker that watches both item channels.
// Predicts each colour from the accepted input items and compares in order.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_colour_checker
  import hsvrgb_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  input  logic hsv_stall,
  input  hsv_t hsv,
  input  logic rgb_valid,
  input  logic rgb_stall,
  input  rgb_t rgb,
  output int   mismatches,
  output int   in_flight
);

  // Colours still owed by the block, oldest first
  rgb_t expected_rgb[$];

  // Exact conversion: every quantity is a numerator over 600000 * f^3
  function automatic rgb_t convert_hsv(hsv_t c);
    logic [63:0] one, sixty, h, s, v, den, n_max, n_min, n_mid, pos, wgt;
    logic [63:0] q_max, q_mid, q_min;
    int unsigned sec_idx;
    sector_t     sec;
    rgb_t        res;
    one   = 64'd1 << FRAC_BITS;
    sixty = 64'd60 * one;
    h     = 64'(c.hue);
    s     = 64'(c.saturation);
    v     = 64'(c.brightness);
    res   = '0;
    if (h > 64'd360 * one || s > 64'd100 * one || v > 64'd100 * one) begin
      res.out_of_range = 1'b1;
      return res;
    end
    den   = 64'd600000 * one * one * one;
    n_max = v * 64'd6000 * one * one;
    n_min = v * (64'd100 * one - s) * sixty;
    // distance into the current pair of sectors, folded back past the middle
    pos   = h % (64'd2 * sixty);
    wgt   = (pos >= sixty) ? (64'd2 * sixty - pos) : pos;
    n_mid = s * v * wgt + n_min;
    q_max = (64'd255 * n_max) / den;
    q_mid = (64'd255 * n_mid) / den;
    q_min = (64'd255 * n_min) / den;
    // hue of exactly 360 lands in the magenta-to-red sector
    sec_idx = int'(h / sixty);
    if (sec_idx > SEC_M_TO_R) sec_idx = SEC_M_TO_R;
    sec = sector_t'(sec_idx);
    case (sec)
      SEC_R_TO_Y: begin
        res.red = q_max[7:0]; res.green = q_mid[7:0]; res.blue = q_min[7:0];
      end
      SEC_Y_TO_G: begin
        res.red = q_mid[7:0]; res.green = q_max[7:0]; res.blue = q_min[7:0];
      end
      SEC_G_TO_C: begin
        res.red = q_min[7:0]; res.green = q_max[7:0]; res.blue = q_mid[7:0];
      end
      SEC_C_TO_B: begin
        res.red = q_min[7:0]; res.green = q_mid[7:0]; res.blue = q_max[7:0];
      end
      SEC_B_TO_M: begin
        res.red = q_mid[7:0]; res.green = q_min[7:0]; res.blue = q_max[7:0];
      end
      default: begin
        res.red = q_max[7:0]; res.green = q_min[7:0]; res.blue = q_mid[7:0];
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  // Sample both channels at the clock edge that accepts an item
  always @(posedge clk) begin
    rgb_t want;
    if (!rst) begin
      if (hsv_valid && !hsv_stall) expected_rgb.push_back(convert_hsv(hsv));
      if (rgb_valid && !rgb_stall) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch($sformatf("result item with none expected: %0d %0d %0d oor %0b",
                                    rgb.red, rgb.green, rgb.blue, rgb.out_of_range));
        end else begin
          want = expected_rgb.pop_front();
          if (rgb.red !== want.red)
            report_mismatch($sformatf("red got %0d, expected %0d", rgb.red, want.red));
          if (rgb.green !== want.green)
            report_mismatch($sformatf("green got %0d, expected %0d", rgb.green, want.green));
          if (rgb.blue !== want.blue)
            report_mismatch($sformatf("blue got %0d, expected %0d", rgb.blue, want.blue));
          if (rgb.out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range got %0b, expected %0b",
                                      rgb.out_of_range, want.out_of_range));
        end
      end
      in_flight = expected_rgb.size();
    end
  end

endmodule

// ----- verif/hsv_to_rgb_converter_tb.sv -----
// HSV to RGB converter testbench top: clock, reset, item stimulus, verdict.
// Drives directed then random colours with random idling on both channels.
// Depends on hsvrgb_pkg, hsv_to_rgb_converter and hsvrgb_colour_checker.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsvrgb_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 3_000_000;
  localparam int HUE_MAX      = 360 * 64;
  localparam int SV_MAX       = 100 * 64;

  logic clk;
  logic rst;
  logic hsv_valid;
  logic hsv_stall;
  hsv_t hsv;
  logic rgb_valid;
  logic rgb_stall;
  rgb_t rgb;
  int   mismatches;
  int   in_flight;

  // Set by the sender after an accept edge, read by the receiver at falling edges
  bit long_hold_req = 1'b0;
  bit no_idle       = 1'b0;

  hsv_to_rgb_converter dut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  hsvrgb_colour_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hsv        (hsv),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .rgb        (rgb),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("hsv_to_rgb_converter_tb: errors");
    $finish;
  end

  function automatic hsv_t colour(int unsigned h, int unsigned s, int unsigned v);
    hsv_t c;
    c.hue        = HUE_W'(h);
    c.saturation = SV_W'(s);
    c.brightness = SV_W'(v);
    return c;
  endfunction

  // Bias towards the ends of the valid range
  function automatic int unsigned near_limit(int unsigned lim);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return lim;
      2:       return lim - 1;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  // Mostly valid colours; some with every field bit free
  function automatic hsv_t random_colour();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      return colour($urandom, $urandom, $urandom);
    else if (pick < 24)
      return colour(near_limit(HUE_MAX), near_limit(SV_MAX), near_limit(SV_MAX));
    else
      return colour($urandom_range(0, HUE_MAX), $urandom_range(0, SV_MAX),
                    $urandom_range(0, SV_MAX));
  endfunction

  // Offer one item, hold it until accepted, then maybe go idle for a burst
  task automatic send_colour(hsv_t c);
    @(negedge clk);
    hsv_valid <= 1'b1;
    hsv       <= c;
    do @(posedge clk); while (hsv_stall);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      hsv_valid <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold on request
  initial begin
    rgb_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rgb_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        rgb_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        rgb_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        rgb_stall <= 1'b0;
      end else begin
        rgb_stall <= 1'b0;
      end
    end
  end

  // Sender: directed colours, then random ones, then drain and verdict
  initial begin
    hsv_t directed[$];
    rst       = 1'b1;
    hsv_valid = 1'b0;
    hsv       = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // full saturation and value every 30 degrees, sector edges and hue 360
    for (int k = 0; k <= 12; k++) directed.push_back(colour(k * 1920, SV_MAX, SV_MAX));
    directed.push_back(colour(0, 0, 0));
    directed.push_back(colour(11520, 0, SV_MAX));
    directed.push_back(colour(7000, SV_MAX, 0));
    directed.push_back(colour(1, 1, 1));
    directed.push_back(colour(HUE_MAX - 1, SV_MAX - 1, SV_MAX - 1));
    directed.push_back(colour(9999, 3200, 4800));
    // just past each valid limit, and all ones
    directed.push_back(colour(HUE_MAX + 1, SV_MAX, SV_MAX));
    directed.push_back(colour(0, SV_MAX + 1, SV_MAX));
    directed.push_back(colour(0, SV_MAX, SV_MAX + 1));
    directed.push_back(colour(32767, 8191, 8191));
    directed.push_back(colour(32767, 0, 0));
    directed.push_back(colour(0, 8191, 0));
    directed.push_back(colour(0, 0, 8191));
    foreach (directed[i]) send_colour(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) long_hold_req = 1'b1;
      // pause until the pipeline has emptied
      if (i == 900) begin
        @(negedge clk);
        hsv_valid <= 1'b0;
        wait (in_flight == 0);
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
      send_colour(random_colour());
    end

    @(negedge clk);
    hsv_valid <= 1'b0;
    wait (in_flight == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("hsv_to_rgb_converter_tb: clean");
    else
      $display("hsv_to_rgb_converter_tb: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
src/hsvrgb_pkg.sv
src/hsvrgb_sector.sv
src/hsvrgb_lane.sv
src/hsv_to_rgb_converter.sv
verif/hsvrgb_colour_checker.sv
verif/hsv_to_rgb_converter_tb.sv
